// ===== rtl/hfl_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hfl_pkg
// Shared types and constants for the hashed frequency leader.
// ----------------------------------------------------------------------------
package hfl_pkg;

    localparam int BUCKETS    = 4096;
    localparam int WAYS       = 4;
    localparam int COUNT_BITS = 20;
    localparam int KEY_BITS   = 37;
    localparam int TIE_BITS   = 15;
    localparam int LEAD_BITS  = 20;
    localparam int BKT_BITS   = $clog2(BUCKETS);
    localparam int MOD_BITS   = 17;
    localparam int KEY_MOD    = 100000;
    localparam int Q_DEPTH    = 4;
    localparam int Q_BITS     = $clog2(Q_DEPTH);

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
    localparam logic [TIE_BITS-1:0]   TIE_MAX   = {TIE_BITS{1'b1}};

    typedef enum logic [0:0] {
        ACT_RECORD = 1'b0,
        ACT_REPORT = 1'b1
    } t_action;

    typedef struct packed {
        t_action               action;
        logic [KEY_BITS-1:0]   key;
        logic [BKT_BITS-1:0]   bucket;
    } t_cmd;

    typedef struct packed {
        logic [KEY_BITS-1:0]   leader_number;
        logic [LEAD_BITS-1:0]  leader_count;
        logic [TIE_BITS-1:0]   tie_count;
        logic                  table_overflow;
    } t_report;

endpackage

// ===== rtl/hashed_frequency_leader.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hashed_frequency_leader
// Counts keys in a bucketed hash table and reports the most frequent key.
// ----------------------------------------------------------------------------
// After reset the back clears all 4096 buckets of the table, one bucket per
// cycle; transfers are still taken until the queue and the front fill up,
// then the input stalls until the clear ends. A record transfer passes the
// front (accept, key mod 100000 at four quotient bits per cycle, hand-off to
// the queue) and then the back (bucket read, way compare and write-back,
// leader update if a count changed); the queue overlaps the two, so the front
// can take a new record while the back still works on the last one. A report
// passes the front and returns one transfer with the current leader.
// ----------------------------------------------------------------------------
module hashed_frequency_leader (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // dial_key[36:0], zero fill
    input  logic        s_axis_tuser,   // action
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [79:0] m_axis_tdata    // leader_number, leader_count, tie_count,
                                        // table_overflow, zero fill
);

    logic             w_f_v, w_f_r, w_q_v, w_q_r;
    hfl_pkg::t_cmd    w_f_cmd, w_q_cmd;
    hfl_pkg::t_report w_rep;

    hfl_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_axis_tvalid),
        .o_ready  (s_axis_tready),
        .i_action (hfl_pkg::t_action'(s_axis_tuser)),
        .i_key    (s_axis_tdata[hfl_pkg::KEY_BITS-1:0]),
        .o_valid  (w_f_v),
        .i_ready  (w_f_r),
        .o_cmd    (w_f_cmd)
    );

    hfl_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_f_v),
        .o_ready (w_f_r),
        .i_cmd   (w_f_cmd),
        .o_valid (w_q_v),
        .i_ready (w_q_r),
        .o_cmd   (w_q_cmd)
    );

    hfl_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_q_v),
        .o_ready (w_q_r),
        .i_cmd   (w_q_cmd),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_rep   (w_rep)
    );

    assign m_axis_tdata = {7'd0, w_rep.table_overflow, w_rep.tie_count,
                           w_rep.leader_count, w_rep.leader_number};

endmodule

// ===== rtl/hfl_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hfl_front
// Accepts input transfers and hashes the key to its bucket. Key mod 100000
// is found by peeling 100000 * 2^k multiples, from the largest k down.
// ----------------------------------------------------------------------------
module hfl_front (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  hfl_pkg::t_action         i_action,
    input  logic [hfl_pkg::KEY_BITS-1:0] i_key,
    output logic                     o_valid,
    input  logic                     i_ready,
    output hfl_pkg::t_cmd            o_cmd
);

    localparam int SH_BITS = $clog2(hfl_pkg::KEY_BITS);
    localparam int TOP_SH  = hfl_pkg::KEY_BITS - hfl_pkg::MOD_BITS;
    localparam int STEP    = 4;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_MOD  = 3'b010,
        S_OUT  = 3'b100
    } t_state;

    t_state                        r_state, n_state;
    hfl_pkg::t_action              r_act;
    logic [hfl_pkg::KEY_BITS-1:0]  r_key;
    logic [hfl_pkg::KEY_BITS-1:0]  r_rem, n_rem;
    logic [SH_BITS-1:0]            r_sh, n_sh;
    logic [hfl_pkg::KEY_BITS+TOP_SH-1:0] w_sub;

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = (r_state == S_OUT);
    assign o_cmd.action = r_act;
    assign o_cmd.key    = r_key;
    assign o_cmd.bucket = r_rem[hfl_pkg::BKT_BITS-1:0];

    always_comb begin
        n_state = r_state;
        n_rem   = r_rem;
        n_sh    = r_sh;
        w_sub   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_rem = i_key;
                    n_sh  = SH_BITS'(TOP_SH);
                    n_state = (i_action == hfl_pkg::ACT_REPORT) ? S_OUT : S_MOD;
                end
            end
            S_MOD: begin
                for (int i = 0; i < STEP; i++) begin
                    w_sub = (hfl_pkg::KEY_BITS+TOP_SH)'(hfl_pkg::KEY_MOD) << n_sh;
                    if ((hfl_pkg::KEY_BITS+TOP_SH)'(n_rem) >= w_sub)
                        n_rem = n_rem - w_sub[hfl_pkg::KEY_BITS-1:0];
                    if (n_sh != '0)
                        n_sh = n_sh - 1'b1;
                end
                if (r_sh < SH_BITS'(STEP))
                    n_state = S_OUT;
            end
            S_OUT: begin
                if (i_ready)
                    n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_rem <= n_rem;
        r_sh  <= n_sh;
        if (r_state == S_IDLE && i_valid) begin
            r_act <= i_action;
            r_key <= i_key;
        end
    end

    a_rem_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && r_act == hfl_pkg::ACT_RECORD) |->
            r_rem < hfl_pkg::KEY_BITS'(hfl_pkg::KEY_MOD))
        else $error("remainder out of range");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> o_valid && $stable(r_key))
        else $error("command dropped");
    a_rdy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_ready)
        else $error("ready while busy");

endmodule

// ===== rtl/hfl_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hfl_queue
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
module hfl_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  hfl_pkg::t_cmd i_cmd,
    output logic          o_valid,
    input  logic          i_ready,
    output hfl_pkg::t_cmd o_cmd
);

    hfl_pkg::t_cmd               r_mem [hfl_pkg::Q_DEPTH];
    logic [hfl_pkg::Q_BITS-1:0]  r_wr, r_rd;
    logic [hfl_pkg::Q_BITS:0]    r_cnt;
    logic                        w_push, w_pop;

    assign o_ready = (r_cnt != (hfl_pkg::Q_BITS+1)'(hfl_pkg::Q_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_mem[r_rd];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) r_wr <= r_wr + 1'b1;
            if (w_pop)  r_rd <= r_rd + 1'b1;
            r_cnt <= r_cnt + (hfl_pkg::Q_BITS+1)'(w_push) - (hfl_pkg::Q_BITS+1)'(w_pop);
        end
        if (w_push) r_mem[r_wr] <= i_cmd;
    end

    a_ptr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (hfl_pkg::Q_BITS+1)'(hfl_pkg::Q_DEPTH))
        else $error("queue count overflow");

endmodule

// ===== rtl/hfl_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hfl_back
// Bucket table and leader tracking. Clears the table after reset, then per
// record command reads a bucket, compares all ways and writes back.
// ----------------------------------------------------------------------------
module hfl_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  hfl_pkg::t_cmd         i_cmd,
    output logic                  o_valid,
    input  logic                  i_ready,
    output hfl_pkg::t_report      o_rep
);

    localparam int WB = (hfl_pkg::WAYS > 1) ? $clog2(hfl_pkg::WAYS) : 1;

    typedef struct packed {
        logic                           valid;
        logic [hfl_pkg::KEY_BITS-1:0]   key;
        logic [hfl_pkg::COUNT_BITS-1:0] count;
    } t_way;

    typedef t_way [hfl_pkg::WAYS-1:0] t_row;

    typedef enum logic [4:0] {
        S_CLR  = 5'b00001,
        S_IDLE = 5'b00010,
        S_RD   = 5'b00100,
        S_UPD  = 5'b01000,
        S_NOTE = 5'b10000
    } t_state;

    t_row                              r_mem [hfl_pkg::BUCKETS];
    t_row                              r_row;
    t_state                            r_state;
    logic [hfl_pkg::BKT_BITS-1:0]      r_clr;
    hfl_pkg::t_cmd                     r_cmd;
    logic [hfl_pkg::KEY_BITS-1:0]      r_best_key;
    logic [hfl_pkg::COUNT_BITS-1:0]    r_best_cnt;
    logic [hfl_pkg::TIE_BITS-1:0]      r_tied;
    logic                              r_drop;
    logic                              r_out_v;
    hfl_pkg::t_report                  r_rep;
    logic [hfl_pkg::COUNT_BITS-1:0]    r_note_cnt;

    logic                              w_hit, w_free;
    logic [WB-1:0]                     w_hit_w, w_free_w;
    t_row                              w_new;
    logic [hfl_pkg::COUNT_BITS-1:0]    w_cnt;
    logic                              w_note;

    assign o_ready = (r_state == S_IDLE) && !r_out_v;
    assign o_valid = r_out_v;
    assign o_rep   = r_rep;

    always_comb begin
        w_hit = 1'b0;
        w_free = 1'b0;
        w_hit_w = '0;
        w_free_w = '0;
        for (int w = 0; w < hfl_pkg::WAYS; w++) begin
            if (r_row[w].valid && r_row[w].key == r_cmd.key && !w_hit) begin
                w_hit = 1'b1;
                w_hit_w = WB'(w);
            end
            if (!r_row[w].valid && !w_free) begin
                w_free = 1'b1;
                w_free_w = WB'(w);
            end
        end
        w_new = r_row;
        w_cnt = '0;
        w_note = 1'b0;
        if (w_hit) begin
            if (r_row[w_hit_w].count != hfl_pkg::COUNT_MAX) begin
                w_cnt = r_row[w_hit_w].count + 1'b1;
                w_new[w_hit_w].count = w_cnt;
                w_note = 1'b1;
            end
        end else if (w_free) begin
            w_cnt = hfl_pkg::COUNT_BITS'(1);
            w_new[w_free_w].valid = 1'b1;
            w_new[w_free_w].key = r_cmd.key;
            w_new[w_free_w].count = w_cnt;
            w_note = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_CLR)
            r_mem[r_clr] <= '0;
        else if (r_state == S_UPD)
            r_mem[r_cmd.bucket] <= w_new;
        r_row <= r_mem[r_cmd.bucket];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLR;
            r_clr      <= '0;
            r_best_key <= '0;
            r_best_cnt <= '0;
            r_tied     <= '0;
            r_drop     <= 1'b0;
            r_out_v    <= 1'b0;
        end else begin
            if (r_out_v && i_ready)
                r_out_v <= 1'b0;
            unique case (r_state)
                S_CLR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == hfl_pkg::BKT_BITS'(hfl_pkg::BUCKETS - 1))
                        r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (i_valid && !r_out_v) begin
                        r_cmd <= i_cmd;
                        if (i_cmd.action == hfl_pkg::ACT_REPORT) begin
                            r_out_v <= 1'b1;
                            r_rep.leader_number  <= r_best_key;
                            r_rep.leader_count   <= hfl_pkg::LEAD_BITS'(r_best_cnt);
                            r_rep.tie_count      <= r_tied;
                            r_rep.table_overflow <= r_drop;
                        end else begin
                            r_state <= S_RD;
                        end
                    end
                end
                S_RD: r_state <= S_UPD;
                S_UPD: begin
                    r_note_cnt <= w_cnt;
                    if (!w_hit && !w_free)
                        r_drop <= 1'b1;
                    r_state <= w_note ? S_NOTE : S_IDLE;
                end
                S_NOTE: begin
                    if (r_note_cnt > r_best_cnt) begin
                        r_best_cnt <= r_note_cnt;
                        r_best_key <= r_cmd.key;
                        r_tied     <= hfl_pkg::TIE_BITS'(1);
                    end else if (r_note_cnt == r_best_cnt) begin
                        if (r_tied != hfl_pkg::TIE_MAX)
                            r_tied <= r_tied + 1'b1;
                        if (r_cmd.key < r_best_key)
                            r_best_key <= r_cmd.key;
                    end
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_drop |=> r_drop)
        else $error("overflow flag cleared");
    a_lead: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_best_cnt != '0) |-> (r_tied != '0))
        else $error("leader without tie count");
    a_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> r_best_cnt >= $past(r_best_cnt))
        else $error("leader count fell");

endmodule
